>>> design/rcrg_pkg.sv
// shared types, constants and op codes of the replay guard
package rcrg_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int MAC_DEPTH   = 8;
	localparam int ID_BYTES    = 3;
	localparam int MAC_BYTES   = 6;

	localparam int OP_W    = 3;
	localparam int NODE_W  = 24;
	localparam int SEQ_W   = 16;
	localparam int STAMP_W = 32;
	localparam int MAC_W   = 48;
	localparam int TRACK_W = 5;
	localparam int REJ_W   = 32;

	localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int MAC_AW     = (MAC_DEPTH > 1) ? $clog2(MAC_DEPTH) : 1;
	localparam int MAC_CNT_W  = $clog2(MAC_DEPTH + 1);
	localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
	localparam int RING_DEPTH = TABLE_SLOTS * MAC_DEPTH;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	localparam logic [NODE_W-1:0] NODE_MASK = (ID_BYTES >= 3) ? {NODE_W{1'b1}} :
		NODE_W'((64'd1 << (8 * ID_BYTES)) - 64'd1);
	localparam logic [MAC_W-1:0] MAC_MASK = (MAC_BYTES >= 6) ? {MAC_W{1'b1}} :
		MAC_W'((64'd1 << (8 * MAC_BYTES)) - 64'd1);

	localparam logic [SEQ_W-1:0] WINDOW_RST = 16'd32;

	typedef enum logic [OP_W-1:0] {
		OP_SEQ    = 3'd0,
		OP_MAC    = 3'd1,
		OP_PRIME  = 3'd2,
		OP_FORGET = 3'd3,
		OP_CHECK  = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef struct packed {
		logic [NODE_W-1:0]    node;
		logic [SEQ_W-1:0]     seq;
		logic [STAMP_W-1:0]   stamp;
		logic [MAC_AW-1:0]    wpos;
		logic [MAC_CNT_W-1:0] fill;
	} slot_ent_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_ent_t         data;
	} slot_wr_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [MAC_W-1:0]   data;
	} ring_wr_t;

endpackage

>>> design/rolling_code_replay_guard.sv
// replay guard top level: sequencer over the node table and mac ring memories
// Usage
//   Input channel (in_valid / in_stall, payload op, node_id, sequence_req, mac):
//   one transaction is one operation on one node. in_stall is high while an
//   operation is being worked on, so one operation is in flight at a time.
//   Output channel (out_valid / out_stall): one result per operation, held in
//   an output register; the next operation is taken while a result waits.
//   Configuration: cfg_valid / cfg_ready / window, cfg_ready always high.
// Operation
//   an operation sweeps the whole node table through its single read port,
//   then passes drain, fetch, evaluate, commit and result. The next
//   transaction is taken once the result is in the output register; a mac
//   operation also compares each stored mac of its slot, the ring memory
//   being read one at a time.
// Reset
//   arst_n empties the table, zeroes the use clock and the reject count and
//   sets window to 32. The memories themselves are not cleared; valid bits
//   per slot and fill counts per ring say what holds data.
// Stall: while out_stall holds a result, a finished operation waits in its
//   last state and no further input is taken.
module rolling_code_replay_guard (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rcrg_pkg::OP_W-1:0]        op,
	input  logic [rcrg_pkg::NODE_W-1:0]      node_id,
	input  logic [rcrg_pkg::SEQ_W-1:0]       sequence_req,
	input  logic [rcrg_pkg::MAC_W-1:0]       mac,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             accepted,
	output logic                             found,
	output logic [rcrg_pkg::SEQ_W-1:0]       stored_sequence,
	output logic [rcrg_pkg::TRACK_W-1:0]     tracked,
	output logic [rcrg_pkg::REJ_W-1:0]       rejected_total,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rcrg_pkg::SEQ_W-1:0]       window
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_FETCH,
		ST_EVAL,
		ST_MAC_RD,
		ST_MAC_CHK,
		ST_COMMIT,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [rcrg_pkg::SEQ_W-1:0]     window_q;
	logic [rcrg_pkg::OP_W-1:0]      op_q;
	logic [rcrg_pkg::NODE_W-1:0]    node_q;
	logic [rcrg_pkg::SEQ_W-1:0]     seq_q;
	logic [rcrg_pkg::MAC_W-1:0]     mac_q;
	logic [rcrg_pkg::TABLE_SLOTS-1:0] used_q;
	logic [rcrg_pkg::STAMP_W-1:0]   clk_cnt_q;
	logic [rcrg_pkg::REJ_W-1:0]     rej_q;

	logic [rcrg_pkg::SLOT_W-1:0]    scan_idx_q;
	logic                           pend_s1;
	logic [rcrg_pkg::SLOT_W-1:0]    idx_s1;
	logic                           found_q;
	logic [rcrg_pkg::SLOT_W-1:0]    match_q;
	logic [rcrg_pkg::SLOT_W-1:0]    min_idx_q;
	logic [rcrg_pkg::STAMP_W-1:0]   min_stamp_q;

	logic [rcrg_pkg::SLOT_W-1:0]    s_q;
	logic                           claim_q;
	rcrg_pkg::slot_ent_t            ent_q;
	logic [rcrg_pkg::MAC_AW-1:0]    mi_q;
	logic                           dup_q;
	logic                           res_acc_q;
	logic [rcrg_pkg::SEQ_W-1:0]     res_seq_q;

	logic                           out_valid_q;
	logic                           acc_out_q;
	logic                           found_out_q;
	logic [rcrg_pkg::SEQ_W-1:0]     seq_out_q;
	logic [rcrg_pkg::TRACK_W-1:0]   track_out_q;
	logic [rcrg_pkg::REJ_W-1:0]     rej_out_q;

	rcrg_pkg::slot_ent_t            slot_rd;
	rcrg_pkg::slot_wr_t             slot_wr;
	logic [rcrg_pkg::SLOT_W-1:0]    slot_rd_addr;
	logic [rcrg_pkg::MAC_W-1:0]     ring_rd;
	rcrg_pkg::ring_wr_t             ring_wr;
	logic [rcrg_pkg::RING_AW-1:0]   ring_rd_addr;
	logic [rcrg_pkg::RING_AW-1:0]   ring_base;

	logic                           free_any;
	logic [rcrg_pkg::SLOT_W-1:0]    free_idx;
	logic [rcrg_pkg::SLOT_W-1:0]    target;
	logic                           needs_claim;
	logic [rcrg_pkg::SEQ_W-1:0]     win_eff;
	logic [rcrg_pkg::SEQ_W-1:0]     seq_gap;
	logic                           in_win;
	logic                           c_ok;
	logic                           c_wr;
	logic                           c_ring;
	logic                           c_tick;
	logic [rcrg_pkg::SEQ_W-1:0]     c_seq;
	rcrg_pkg::slot_ent_t            ent_n;
	logic [rcrg_pkg::CNT_W-1:0]     used_cnt;
	logic [rcrg_pkg::MAC_CNT_W-1:0] mi_next;
	logic                           out_free;

	rcrg_slot_mem u_slot_mem (
		.clk     (clk),
		.rd_addr (slot_rd_addr),
		.wr      (slot_wr),
		.rd_data (slot_rd)
	);

	rcrg_mac_mem u_mac_mem (
		.clk     (clk),
		.rd_addr (ring_rd_addr),
		.wr      (ring_wr),
		.rd_data (ring_rd)
	);

	// first free slot, lowest index wins
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = rcrg_pkg::TABLE_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = rcrg_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		used_cnt = '0;
		for (int i = 0; i < rcrg_pkg::TABLE_SLOTS; i++) begin
			used_cnt = used_cnt + rcrg_pkg::CNT_W'(used_q[i]);
		end
	end

	assign target = found_q ? match_q : (free_any ? free_idx : min_idx_q);
	assign needs_claim = !found_q && (op_q == rcrg_pkg::OP_SEQ ||
		op_q == rcrg_pkg::OP_MAC || op_q == rcrg_pkg::OP_PRIME);

	assign slot_rd_addr = (state_q == ST_FETCH) ? target : scan_idx_q;
	assign ring_base    = rcrg_pkg::RING_AW'(s_q) * rcrg_pkg::RING_AW'(rcrg_pkg::MAC_DEPTH);
	assign ring_rd_addr = ring_base + rcrg_pkg::RING_AW'(mi_q);
	assign mi_next      = rcrg_pkg::MAC_CNT_W'(mi_q) + rcrg_pkg::MAC_CNT_W'(1);

	assign win_eff = (window_q == '0) ? rcrg_pkg::SEQ_W'(1) : window_q;
	assign seq_gap = seq_q - ent_q.seq;
	assign in_win  = (seq_gap != '0) && (seq_gap <= win_eff);

	// commit decision for the operation in hand
	always_comb begin
		c_ok   = 1'b0;
		c_wr   = 1'b0;
		c_ring = 1'b0;
		c_tick = 1'b0;
		c_seq  = found_q ? ent_q.seq : '0;
		ent_n  = ent_q;
		unique case (op_q)
			rcrg_pkg::OP_SEQ: begin
				c_ok = !found_q || in_win;
				if (c_ok) begin
					c_wr        = 1'b1;
					c_tick      = 1'b1;
					ent_n.seq   = seq_q;
					ent_n.stamp = clk_cnt_q + rcrg_pkg::STAMP_W'(1);
					c_seq       = seq_q;
				end
			end
			rcrg_pkg::OP_MAC: begin
				c_ok  = !dup_q;
				c_wr  = 1'b1;
				c_seq = ent_q.seq;
				if (c_ok) begin
					c_ring      = 1'b1;
					c_tick      = 1'b1;
					ent_n.stamp = clk_cnt_q + rcrg_pkg::STAMP_W'(1);
					ent_n.wpos  = (ent_q.wpos == rcrg_pkg::MAC_AW'(rcrg_pkg::MAC_DEPTH - 1)) ?
						'0 : ent_q.wpos + rcrg_pkg::MAC_AW'(1);
					if (ent_q.fill < rcrg_pkg::MAC_CNT_W'(rcrg_pkg::MAC_DEPTH)) begin
						ent_n.fill = ent_q.fill + rcrg_pkg::MAC_CNT_W'(1);
					end
				end
			end
			rcrg_pkg::OP_PRIME: begin
				c_ok        = 1'b1;
				c_wr        = 1'b1;
				c_tick      = 1'b1;
				ent_n.seq   = seq_q;
				ent_n.stamp = clk_cnt_q + rcrg_pkg::STAMP_W'(1);
				c_seq       = seq_q;
			end
			rcrg_pkg::OP_FORGET: begin
				c_ok  = found_q;
				c_seq = '0;
			end
			rcrg_pkg::OP_CHECK: begin
				c_ok = !found_q || in_win;
			end
			rcrg_pkg::OP_CLEAR: begin
				c_ok  = 1'b1;
				c_seq = '0;
			end
			default: begin
				c_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		slot_wr.en   = (state_q == ST_COMMIT) && c_wr;
		slot_wr.addr = s_q;
		slot_wr.data = ent_n;
		ring_wr.en   = (state_q == ST_COMMIT) && c_ring;
		ring_wr.addr = ring_base + rcrg_pkg::RING_AW'(ent_q.wpos);
		ring_wr.data = mac_q;
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= rcrg_pkg::WINDOW_RST;
			used_q      <= '0;
			clk_cnt_q   <= '0;
			rej_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				window_q <= window;
			end
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			// table sweep: data of the previous address arrives this cycle
			pend_s1 <= (state_q == ST_SCAN);
			idx_s1  <= scan_idx_q;
			if (pend_s1) begin
				if (used_q[idx_s1] && slot_rd.node == node_q && !found_q) begin
					found_q <= 1'b1;
					match_q <= idx_s1;
				end
				if (idx_s1 == '0 || slot_rd.stamp < min_stamp_q) begin
					min_stamp_q <= slot_rd.stamp;
					min_idx_q   <= idx_s1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q       <= op;
						node_q     <= node_id & rcrg_pkg::NODE_MASK;
						seq_q      <= sequence_req;
						mac_q      <= mac & rcrg_pkg::MAC_MASK;
						found_q    <= 1'b0;
						scan_idx_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == rcrg_pkg::SLOT_W'(rcrg_pkg::TABLE_SLOTS - 1)) begin
						state_q <= ST_SCAN_END;
					end else begin
						scan_idx_q <= scan_idx_q + rcrg_pkg::SLOT_W'(1);
					end
				end
				ST_SCAN_END: begin
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					s_q     <= target;
					claim_q <= needs_claim;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					// a claimed slot starts out wiped
					if (claim_q) begin
						ent_q <= {node_q,
							{($bits(rcrg_pkg::slot_ent_t) - rcrg_pkg::NODE_W){1'b0}}};
					end else begin
						ent_q <= slot_rd;
					end
					dup_q <= 1'b0;
					mi_q  <= '0;
					if (op_q == rcrg_pkg::OP_MAC && !claim_q && slot_rd.fill != '0) begin
						state_q <= ST_MAC_RD;
					end else begin
						state_q <= ST_COMMIT;
					end
				end
				ST_MAC_RD: begin
					state_q <= ST_MAC_CHK;
				end
				ST_MAC_CHK: begin
					if (ring_rd == mac_q) begin
						dup_q   <= 1'b1;
						state_q <= ST_COMMIT;
					end else if (mi_next == ent_q.fill) begin
						state_q <= ST_COMMIT;
					end else begin
						mi_q    <= mi_next[rcrg_pkg::MAC_AW-1:0];
						state_q <= ST_MAC_RD;
					end
				end
				ST_COMMIT: begin
					res_acc_q <= c_ok;
					res_seq_q <= c_seq;
					if (c_wr) begin
						used_q[s_q] <= 1'b1;
					end
					if (c_tick) begin
						clk_cnt_q <= clk_cnt_q + rcrg_pkg::STAMP_W'(1);
					end
					if ((op_q == rcrg_pkg::OP_SEQ || op_q == rcrg_pkg::OP_MAC) && !c_ok) begin
						rej_q <= rej_q + rcrg_pkg::REJ_W'(1);
					end
					if (op_q == rcrg_pkg::OP_FORGET && found_q) begin
						used_q[s_q] <= 1'b0;
					end
					if (op_q == rcrg_pkg::OP_CLEAR) begin
						used_q    <= '0;
						clk_cnt_q <= '0;
						rej_q     <= '0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						acc_out_q   <= res_acc_q;
						found_out_q <= found_q;
						seq_out_q   <= res_seq_q;
						track_out_q <= rcrg_pkg::TRACK_W'(used_cnt);
						rej_out_q   <= rej_q;
						state_q     <= ST_IDLE;
					end else begin
						out_valid_q <= out_valid_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = acc_out_q;
	assign found           = found_out_q;
	assign stored_sequence = seq_out_q;
	assign tracked         = track_out_q;
	assign rejected_total  = rej_out_q;

`ifndef SYNTHESIS
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && op_q == rcrg_pkg::OP_CLEAR) |=> (used_q == '0))
		else $error("clear left table entries in use");

	a_new_node_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && op_q == rcrg_pkg::OP_SEQ && !found_q) |=> used_q[$past(s_q)])
		else $error("first sequence of a new node did not take a slot");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_wr.en |-> (slot_wr.data.fill <= rcrg_pkg::MAC_CNT_W'(rcrg_pkg::MAC_DEPTH)))
		else $error("mac fill count beyond ring depth");

	a_take_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_SCAN && scan_idx_q == '0))
		else $error("accepted transaction did not start a table sweep");

	a_tracked_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tracked <= rcrg_pkg::TRACK_W'(rcrg_pkg::TABLE_SLOTS)))
		else $error("tracked count beyond table size");
`endif

endmodule

>>> design/rcrg_slot_mem.sv
// node table memory: one entry per slot, registered read
module rcrg_slot_mem (
	input  logic                             clk,
	input  logic [rcrg_pkg::SLOT_W-1:0]      rd_addr,
	input  rcrg_pkg::slot_wr_t               wr,
	output rcrg_pkg::slot_ent_t              rd_data
);

	rcrg_pkg::slot_ent_t mem [rcrg_pkg::TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/rcrg_mac_mem.sv
// mac ring memory: all slots' recent macs, registered read
module rcrg_mac_mem (
	input  logic                              clk,
	input  logic [rcrg_pkg::RING_AW-1:0]      rd_addr,
	input  rcrg_pkg::ring_wr_t                wr,
	output logic [rcrg_pkg::MAC_W-1:0]        rd_data
);

	logic [rcrg_pkg::MAC_W-1:0] mem [rcrg_pkg::RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> bench/tb.sv
// self-checking testbench for the rolling-code replay guard
`timescale 1ns / 1ps
module tb;

	typedef struct packed {
		logic [rcrg_pkg::OP_W-1:0]   op;
		logic [rcrg_pkg::NODE_W-1:0] node;
		logic [rcrg_pkg::SEQ_W-1:0]  seq;
		logic [rcrg_pkg::MAC_W-1:0]  code;
	} frame_t;

	typedef struct packed {
		logic                         ok;
		logic                         hit;
		logic [rcrg_pkg::SEQ_W-1:0]   seq;
		logic [rcrg_pkg::TRACK_W-1:0] cnt;
		logic [rcrg_pkg::REJ_W-1:0]   rej;
	} verdict_t;

	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;
	// op codes with no operation behind them
	localparam logic [rcrg_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [rcrg_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [rcrg_pkg::OP_W-1:0] op = '0;
	logic [rcrg_pkg::NODE_W-1:0] node_id = '0;
	logic [rcrg_pkg::SEQ_W-1:0] sequence_req = '0;
	logic [rcrg_pkg::MAC_W-1:0] mac = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic accepted, found;
	logic [rcrg_pkg::SEQ_W-1:0] stored_sequence;
	logic [rcrg_pkg::TRACK_W-1:0] tracked;
	logic [rcrg_pkg::REJ_W-1:0] rejected_total;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rcrg_pkg::SEQ_W-1:0] window = '0;

	rolling_code_replay_guard dut (.*);

	// guard model state
	logic                         g_used [rcrg_pkg::TABLE_SLOTS];
	logic [rcrg_pkg::NODE_W-1:0]  g_node [rcrg_pkg::TABLE_SLOTS];
	logic [rcrg_pkg::SEQ_W-1:0]   g_seq  [rcrg_pkg::TABLE_SLOTS];
	logic [31:0]                  g_stamp[rcrg_pkg::TABLE_SLOTS];
	logic [rcrg_pkg::MAC_W-1:0]   g_ring [rcrg_pkg::TABLE_SLOTS][rcrg_pkg::MAC_DEPTH];
	int                           g_wpos [rcrg_pkg::TABLE_SLOTS];
	int                           g_fill [rcrg_pkg::TABLE_SLOTS];
	logic [31:0]                  g_clock;
	logic [31:0]                  g_rej;
	logic [rcrg_pkg::SEQ_W-1:0]   g_window;

	frame_t   pending_frames[$];
	verdict_t expected_verdicts[$];
	int       fail_count = 0;
	bit       quiet = 1'b0;
	bit       feed_done = 1'b0;
	int       in_gap = 0, out_gap = 0;
	int       idle_cycles = 0;

	function automatic logic [rcrg_pkg::NODE_W-1:0] rnd_node();
		return rcrg_pkg::NODE_W'($urandom);
	endfunction

	function automatic logic [rcrg_pkg::SEQ_W-1:0] rnd_seq();
		return rcrg_pkg::SEQ_W'($urandom);
	endfunction

	function automatic logic [rcrg_pkg::MAC_W-1:0] rnd_mac();
		return rcrg_pkg::MAC_W'({$urandom, $urandom});
	endfunction

	function automatic void wipe_entry(int s);
		g_used[s] = 1'b0; g_node[s] = '0; g_seq[s] = '0; g_stamp[s] = '0;
		g_wpos[s] = 0; g_fill[s] = 0;
	endfunction

	function automatic void guard_reset();
		for (int i = 0; i < rcrg_pkg::TABLE_SLOTS; i++) wipe_entry(i);
		g_clock = '0; g_rej = '0; g_window = rcrg_pkg::WINDOW_RST;
	endfunction

	function automatic int claim_entry(logic [rcrg_pkg::NODE_W-1:0] n);
		int v;
		v = -1;
		for (int i = 0; i < rcrg_pkg::TABLE_SLOTS; i++)
			if (v < 0 && !g_used[i]) v = i;
		if (v < 0) begin
			v = 0;
			for (int i = 1; i < rcrg_pkg::TABLE_SLOTS; i++)
				if (g_stamp[i] < g_stamp[v]) v = i;
		end
		wipe_entry(v);
		g_node[v] = n;
		g_used[v] = 1'b1;
		return v;
	endfunction

	function automatic bit seq_in_window(int s, logic [rcrg_pkg::SEQ_W-1:0] q);
		logic [rcrg_pkg::SEQ_W-1:0] d, w;
		d = q - g_seq[s];
		w = (g_window == '0) ? 16'd1 : g_window;
		return d != '0 && d <= w;
	endfunction

	function automatic verdict_t guard_step(frame_t f);
		verdict_t r;
		int s, cnt;
		bit hit, ok;
		logic [rcrg_pkg::NODE_W-1:0] n;
		logic [rcrg_pkg::MAC_W-1:0] m;
		n = f.node & rcrg_pkg::NODE_MASK;
		m = f.code & rcrg_pkg::MAC_MASK;
		s = -1;
		for (int i = 0; i < rcrg_pkg::TABLE_SLOTS; i++)
			if (s < 0 && g_used[i] && g_node[i] == n) s = i;
		hit = s >= 0;
		ok = 1'b0;
		case (f.op)
			rcrg_pkg::OP_SEQ: begin
				if (!hit || seq_in_window(s, f.seq)) begin
					if (!hit) s = claim_entry(n);
					g_seq[s] = f.seq;
					g_clock++;
					g_stamp[s] = g_clock;
					ok = 1'b1;
				end else g_rej++;
			end
			rcrg_pkg::OP_MAC: begin
				if (!hit) s = claim_entry(n);
				ok = 1'b1;
				for (int i = 0; i < g_fill[s]; i++)
					if (g_ring[s][i] == m) ok = 1'b0;
				if (!ok) g_rej++;
				else begin
					g_ring[s][g_wpos[s]] = m;
					g_wpos[s] = (g_wpos[s] + 1) % rcrg_pkg::MAC_DEPTH;
					if (g_fill[s] < rcrg_pkg::MAC_DEPTH) g_fill[s]++;
					g_clock++;
					g_stamp[s] = g_clock;
				end
			end
			rcrg_pkg::OP_PRIME: begin
				if (!hit) s = claim_entry(n);
				g_seq[s] = f.seq;
				g_clock++;
				g_stamp[s] = g_clock;
				ok = 1'b1;
			end
			rcrg_pkg::OP_FORGET: begin
				if (hit) begin
					wipe_entry(s);
					ok = 1'b1;
				end
				s = -1;
			end
			rcrg_pkg::OP_CHECK: ok = hit ? seq_in_window(s, f.seq) : 1'b1;
			rcrg_pkg::OP_CLEAR: begin
				for (int i = 0; i < rcrg_pkg::TABLE_SLOTS; i++) wipe_entry(i);
				g_clock = '0; g_rej = '0;
				s = -1;
				ok = 1'b1;
			end
			default: ;
		endcase
		cnt = 0;
		for (int i = 0; i < rcrg_pkg::TABLE_SLOTS; i++) cnt += int'(g_used[i]);
		r.ok = ok;
		r.hit = hit;
		r.seq = (s >= 0 && g_used[s]) ? g_seq[s] : '0;
		r.cnt = cnt[rcrg_pkg::TRACK_W-1:0];
		r.rej = g_rej;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial forever #5 clk = ~clk;

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_verdicts.push_back(guard_step({op, node_id, sequence_req, mac}));
				if (!quiet) in_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_frames.size() > 0) begin
					frame_t f;
					f = pending_frames.pop_front();
					in_valid <= 1'b1;
					op <= f.op; node_id <= f.node; sequence_req <= f.seq; mac <= f.code;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("unexpected result", '0, '0);
				end else begin
					verdict_t e;
					e = expected_verdicts.pop_front();
					if (accepted !== e.ok) report_mismatch("accepted", 64'(accepted), 64'(e.ok));
					if (found !== e.hit) report_mismatch("found", 64'(found), 64'(e.hit));
					if (stored_sequence !== e.seq)
						report_mismatch("stored_sequence", 64'(stored_sequence), 64'(e.seq));
					if (tracked !== e.cnt) report_mismatch("tracked", 64'(tracked), 64'(e.cnt));
					if (rejected_total !== e.rej)
						report_mismatch("rejected_total", 64'(rejected_total), 64'(e.rej));
				end
			end
			if (quiet) out_stall <= 1'b0;
			else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 16);
				out_stall <= 1'b1;
			end else out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
			idle_cycles <= 0;
		else if (!feed_done) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic frame_t mk(logic [rcrg_pkg::OP_W-1:0] o, logic [rcrg_pkg::NODE_W-1:0] n,
		logic [rcrg_pkg::SEQ_W-1:0] q, logic [rcrg_pkg::MAC_W-1:0] m);
		frame_t f;
		f.op = o; f.node = n; f.seq = q; f.code = m;
		return f;
	endfunction

	task automatic wait_idle();
		while (pending_frames.size() > 0 || in_valid || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(logic [rcrg_pkg::SEQ_W-1:0] w);
		window <= w;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		g_window = w;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random traffic over a small node pool so that hits, evictions and replays happen
	task automatic random_phase(int count, int pool);
		logic [rcrg_pkg::NODE_W-1:0] ids[24];
		logic [rcrg_pkg::SEQ_W-1:0] last[24];
		logic [rcrg_pkg::MAC_W-1:0] seen[24];
		logic [rcrg_pkg::OP_W-1:0] o;
		int k, r;
		for (int i = 0; i < 24; i++) begin
			ids[i] = (i < 2) ? (i == 0 ? 24'h000000 : 24'hFFFFFF) : rnd_node();
			last[i] = rnd_seq(); seen[i] = rnd_mac();
		end
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, pool - 1);
			r = $urandom_range(0, 99);
			if (r < 35) begin
				last[k] = last[k] + (($urandom_range(0, 4) == 0) ?
					rnd_seq() : rcrg_pkg::SEQ_W'($urandom_range(0, g_window + 2)));
				pending_frames.push_back(mk(rcrg_pkg::OP_SEQ, ids[k], last[k], rnd_mac()));
			end else if (r < 60) begin
				if ($urandom_range(0, 2) != 0) seen[k] = rnd_mac();
				pending_frames.push_back(mk(rcrg_pkg::OP_MAC, ids[k], rnd_seq(), seen[k]));
			end else if (r < 70)
				pending_frames.push_back(mk(rcrg_pkg::OP_PRIME, ids[k], rnd_seq(), rnd_mac()));
			else if (r < 77)
				pending_frames.push_back(mk(rcrg_pkg::OP_FORGET, ids[k], rnd_seq(), rnd_mac()));
			else if (r < 92)
				pending_frames.push_back(mk(rcrg_pkg::OP_CHECK, ids[k],
					last[k] + rcrg_pkg::SEQ_W'($urandom_range(0, 40)), rnd_mac()));
			else if (r < 93)
				pending_frames.push_back(mk(rcrg_pkg::OP_CLEAR, rnd_node(), rnd_seq(), rnd_mac()));
			else if (r < 96) begin
				o = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
				pending_frames.push_back(mk(o, ids[k], rnd_seq(), rnd_mac()));
			end else begin
				o = rcrg_pkg::OP_W'($urandom_range(rcrg_pkg::OP_SEQ, rcrg_pkg::OP_CHECK));
				pending_frames.push_back(mk(o, rnd_node(), rnd_seq(), rnd_mac()));
			end
		end
	endtask

	initial begin
		guard_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every op and the special cases
		pending_frames.push_back(mk(rcrg_pkg::OP_CHECK, 24'hABCDEF, 16'h0000, '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_FORGET, 24'hABCDEF, 16'h0000, '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_SEQ, 24'hFFFFFF, 16'hFFF0, '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_SEQ, 24'hFFFFFF, 16'h0010, '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_SEQ, 24'hFFFFFF, 16'h0010, '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_SEQ, 24'hFFFFFF, 16'h0031, '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_CHECK, 24'hFFFFFF, 16'h0030, '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_MAC, 24'h000000, 16'hFFFF, 48'hFFFFFFFFFFFF));
		pending_frames.push_back(mk(rcrg_pkg::OP_MAC, 24'h000000, 16'h0000, 48'hFFFFFFFFFFFF));
		pending_frames.push_back(mk(rcrg_pkg::OP_MAC, 24'h000000, 16'h0000, 48'h000000000000));
		pending_frames.push_back(mk(rcrg_pkg::OP_PRIME, 24'h123456, 16'h8000, '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_FORGET, 24'h123456, 16'h0000, '0));
		pending_frames.push_back(mk(OP_SPARE_LO, 24'hFFFFFF, 16'hFFFF, 48'hFFFFFFFFFFFF));
		pending_frames.push_back(mk(OP_SPARE_HI, 24'h000000, 16'h0000, '0));
		for (int i = 0; i < 9; i++)
			pending_frames.push_back(mk(rcrg_pkg::OP_PRIME, rcrg_pkg::NODE_W'(24'h100 + i),
				rcrg_pkg::SEQ_W'(i), '0));
		pending_frames.push_back(mk(rcrg_pkg::OP_CLEAR, 24'h0, 16'h0, '0));
		wait_idle();

		write_window(16'd0);
		random_phase(120, 6);
		wait_idle();
		write_window(16'hFFFF);
		random_phase(150, 20);
		wait_idle();
		write_window(rcrg_pkg::SEQ_W'($urandom_range(1, 200)));
		random_phase(300, 20);
		wait_idle();
		write_window(16'd32);
		random_phase(200, 12);
		wait_idle();
		quiet = 1'b1;
		random_phase(130, 18);
		wait_idle();
		feed_done = 1'b1;

		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
